@@ hdl/arp_pkg.sv @@
// ----------------------------------------------------------------------------
// arp_pkg: shared types and constants of the ATT response parser
// Opcodes, result kinds, end status codes, queue sizing and record types.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int unsigned MAX_PDU_BYTES  = 256;
  localparam int unsigned MAX_UUID_BYTES = 16;
  localparam int unsigned UUID_STORE     = 16;  // bytes of UUID storage (fixed by outputs)
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned POS_W  = $clog2(MAX_PDU_BYTES + 1);
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] OP_ERROR   = 8'h01;
  localparam logic [7:0] OP_BY_TYPE = 8'h09;
  localparam logic [7:0] OP_READ    = 8'h0B;
  localparam logic [7:0] OP_GROUP   = 8'h11;

  localparam logic [7:0] CHR_HDR_LEN = 8'd5;  // decl handle, properties, value handle
  localparam logic [7:0] SVC_HDR_LEN = 8'd4;  // start handle, end handle

  typedef enum logic [2:0] {
    KIND_ERROR   = 3'd0,
    KIND_CHAR    = 3'd1,
    KIND_VALUE   = 3'd2,
    KIND_SERVICE = 3'd3,
    KIND_END     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ERROR_RSP = 2'd1,
    ST_UNHANDLED = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  // data record produced by one byte (error, characteristic, value or service)
  typedef struct packed {
    kind_e        kind;
    logic [7:0]   record_index;
    logic [15:0]  first_handle;
    logic [15:0]  second_handle;
    logic [7:0]   attr_byte;
    logic [7:0]   err_code;
    logic [4:0]   uuid_bytes;
    logic [63:0]  uuid_low;
    logic [63:0]  uuid_high;
  } rec_t;

  // everything one input byte causes: optional data record, optional end status
  typedef struct packed {
    logic         has_main;
    logic         has_end;
    rec_t         main;
    status_e      end_status;
    logic [7:0]   end_count;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hdl/arp_if.sv @@
// ----------------------------------------------------------------------------
// arp_if: channel interfaces of the ATT response parser
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface arp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       clear_index;

  modport source (output valid, output data_byte, output last_byte, output clear_index,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input clear_index,
                  output ready);
endinterface

interface arp_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  record_index;
  logic [15:0] first_handle;
  logic [15:0] second_handle;
  logic [7:0]  attr_byte;
  logic [7:0]  err_code;
  logic [4:0]  uuid_bytes;
  logic [63:0] uuid_low;
  logic [63:0] uuid_high;
  logic [1:0]  status;
  logic [7:0]  entry_count;
  logic        last;

  modport source (output valid, output kind, output record_index, output first_handle,
                  output second_handle, output attr_byte, output err_code,
                  output uuid_bytes, output uuid_low, output uuid_high, output status,
                  output entry_count, output last, input ready);
  modport sink   (input valid, input kind, input record_index, input first_handle,
                  input second_handle, input attr_byte, input err_code,
                  input uuid_bytes, input uuid_low, input uuid_high, input status,
                  input entry_count, input last, output ready);
endinterface

@@ hdl/att_response_parser_top.sv @@
// ----------------------------------------------------------------------------
// att_response_parser_top: streaming Bluetooth LE ATT response parser
// Front classifier, bundle queue and result emitter.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i carries one PDU byte per transaction (opcode first), with
//   last_byte on the final byte and clear_index sampled on the opcode byte.
//   rec_o carries result records: error, characteristic, value byte,
//   service and end status; last marks the final record of one input byte.
// Path: a taken byte is written into the queue, then loaded into the
//   emitter register, whose contents drive its first record onto rec_o.
// Throughput: one byte per cycle while each byte yields at most one record
//   and rec_o.ready stays high; a byte yielding a data record and an end
//   status holds the emitter for both records. The four-entry bundle queue
//   between front and emitter absorbs these bursts.
// Stall: when rec_o.ready is low the emitter holds its record, the queue
//   fills, and byte_i.ready drops only once the queue is full.
// Reset: rst_ni (async, active low) clears all parse state, the running
//   characteristic index and the queue; nothing is pending after reset.
// ----------------------------------------------------------------------------
module att_response_parser_top import arp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  arp_byte_if.sink    byte_i,
  arp_rec_if.source   rec_o
);

  logic       push;
  bundle_t    push_data;
  logic       pop;
  bundle_t    pop_data;
  q_status_t  q_status;

  // byte classification and PDU state
  arp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples the byte stream from the result receiver
  arp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // unpacks bundles into result transactions
  arp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .q_status_i (q_status),
    .pop_o      (pop),
    .rec_o      (rec_o)
  );

endmodule

@@ hdl/arp_front.sv @@
// ----------------------------------------------------------------------------
// arp_front: byte classifier and PDU state of the ATT response parser
// Updates parse state for every accepted byte and pushes the resulting bundle when it holds a record or an end status.
// ----------------------------------------------------------------------------
module arp_front import arp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  arp_byte_if.sink      byte_i,
  input  q_status_t     q_status_i,
  output logic          push_o,
  output bundle_t       push_data_o
);

  logic [POS_W-1:0]          pos_q, pos_d, pos_inc;
  logic [7:0]                opcode_q, opcode_d;
  logic [7:0]                len_q, len_d;
  logic [4:0]                ebc_q, ebc_d;
  logic [15:0]               h0_q, h0_d, h1_q, h1_d;
  logic [7:0]                prop_q, prop_d;
  logic [UUID_STORE-1:0][7:0] uuid_q, uuid_d;
  logic [7:0]                err0_q, err0_d, err1_q, err1_d;
  logic [7:0]                cidx_q, cidx_d;
  logic [7:0]                cnt_q, cnt_d;
  logic                      mal_q, mal_d;

  logic                      acc;
  logic                      chr;
  logic [7:0]                b;
  logic [3:0]                uk;
  logic [7:0]                ulen;
  logic [8:0]                lo_len;
  logic [7:0]                cnt_bump;
  bundle_t                   bun;

  assign byte_i.ready = !q_status_i.full;
  assign acc          = byte_i.valid && byte_i.ready;
  assign b            = byte_i.data_byte;
  assign chr          = (opcode_q == OP_BY_TYPE);
  assign cnt_bump     = (cnt_q != 8'hFF) ? cnt_q + 8'd1 : cnt_q;
  assign lo_len       = chr ? {1'b0, CHR_HDR_LEN} : {1'b0, SVC_HDR_LEN};
  assign ulen         = len_q - (chr ? CHR_HDR_LEN : SVC_HDR_LEN);
  assign pos_inc      = (pos_q < POS_W'(MAX_PDU_BYTES)) ? pos_q + POS_W'(1) : pos_q;

  always_comb begin
    pos_d    = pos_q;
    opcode_d = opcode_q;
    len_d    = len_q;
    ebc_d    = ebc_q;
    h0_d     = h0_q;
    h1_d     = h1_q;
    prop_d   = prop_q;
    uuid_d   = uuid_q;
    err0_d   = err0_q;
    err1_d   = err1_q;
    cidx_d   = cidx_q;
    cnt_d    = cnt_q;
    mal_d    = mal_q;
    uk       = '0;
    bun      = '0;

    if (acc) begin
      if (pos_q == '0) begin
        opcode_d = b;
        len_d    = '0;
        ebc_d    = '0;
        h0_d     = '0;
        h1_d     = '0;
        prop_d   = '0;
        uuid_d   = '0;
        err0_d   = '0;
        err1_d   = '0;
        cnt_d    = '0;
        mal_d    = 1'b0;
        if (byte_i.clear_index) begin
          cidx_d = '0;
        end
      end else if (pos_q >= POS_W'(MAX_PDU_BYTES)) begin
        mal_d = 1'b1;
      end else if (opcode_q == OP_ERROR) begin
        if (pos_q == POS_W'(1)) begin
          err0_d = b;
        end else if (pos_q == POS_W'(2)) begin
          h0_d = {8'h00, b};
        end else if (pos_q == POS_W'(3)) begin
          h0_d = {b, h0_q[7:0]};
        end else if (pos_q == POS_W'(4)) begin
          err1_d                = b;
          bun.has_main          = 1'b1;
          bun.main.kind         = KIND_ERROR;
          bun.main.first_handle = h0_q;
          bun.main.attr_byte    = err0_q;
          bun.main.err_code     = b;
          cnt_d                 = cnt_bump;
        end
      end else if (opcode_q == OP_BY_TYPE || opcode_q == OP_GROUP) begin
        if (!mal_q) begin
          if (pos_q == POS_W'(1)) begin
            len_d = b;
            ebc_d = '0;
            if ({1'b0, b} < lo_len || {1'b0, b} > lo_len + 9'(MAX_UUID_BYTES)) begin
              mal_d = 1'b1;
            end
          end else begin
            // entry body: handles (and, for characteristics, properties) first, then UUID bytes
            if (ebc_q == 5'd0) begin
              uuid_d = '0;
              h0_d   = {8'h00, b};
            end else if (ebc_q == 5'd1) begin
              h0_d = {b, h0_q[7:0]};
            end else if (chr) begin
              if (ebc_q == 5'd2) begin
                prop_d = b;
              end else if (ebc_q == 5'd3) begin
                h1_d = {8'h00, b};
              end else if (ebc_q == 5'd4) begin
                h1_d = {b, h1_q[7:0]};
              end else begin
                uk         = 4'(ebc_q - 5'd5);
                uuid_d[uk] = uuid_q[uk] | b;
              end
            end else begin
              if (ebc_q == 5'd2) begin
                h1_d = {8'h00, b};
              end else if (ebc_q == 5'd3) begin
                h1_d = {b, h1_q[7:0]};
              end else begin
                // service UUID arrives little-endian, stored reversed
                uk         = 4'(len_q - 8'd1 - {3'b000, ebc_q});
                uuid_d[uk] = uuid_q[uk] | b;
              end
            end

            if ({3'b000, ebc_q} + 8'd1 >= len_q) begin
              bun.has_main           = 1'b1;
              bun.main.kind          = chr ? KIND_CHAR : KIND_SERVICE;
              bun.main.record_index  = chr ? cidx_q : cnt_q;
              bun.main.first_handle  = h0_d;
              bun.main.second_handle = h1_d;
              bun.main.attr_byte     = chr ? prop_d : 8'h00;
              bun.main.uuid_bytes    = ulen[4:0];
              bun.main.uuid_low      = uuid_d[7:0];
              bun.main.uuid_high     = uuid_d[15:8];
              if (chr) begin
                cidx_d = cidx_q + 8'd1;
              end
              cnt_d = cnt_bump;
              ebc_d = '0;
            end else begin
              ebc_d = ebc_q + 5'd1;
            end
          end
        end
      end else if (opcode_q == OP_READ) begin
        bun.has_main          = 1'b1;
        bun.main.kind         = KIND_VALUE;
        bun.main.record_index = cnt_q;
        bun.main.attr_byte    = b;
        cnt_d                 = cnt_bump;
      end

      pos_d = pos_inc;

      if (byte_i.last_byte) begin
        bun.has_end   = 1'b1;
        bun.end_count = cnt_d;
        if (mal_d) begin
          bun.end_status = ST_MALFORMED;
        end else if (opcode_d == OP_ERROR) begin
          bun.end_status = (cnt_d != 8'h00) ? ST_ERROR_RSP : ST_MALFORMED;
        end else if (opcode_d == OP_BY_TYPE || opcode_d == OP_GROUP) begin
          bun.end_status = (pos_inc < POS_W'(2)) ? ST_MALFORMED : ST_OK;
        end else if (opcode_d == OP_READ) begin
          bun.end_status = ST_OK;
        end else begin
          bun.end_status = ST_UNHANDLED;
        end
        pos_d = '0;
      end
    end
  end

  assign push_o      = acc && (bun.has_main || bun.has_end);
  assign push_data_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      opcode_q <= '0;
      len_q    <= '0;
      ebc_q    <= '0;
      h0_q     <= '0;
      h1_q     <= '0;
      prop_q   <= '0;
      uuid_q   <= '0;
      err0_q   <= '0;
      err1_q   <= '0;
      cidx_q   <= '0;
      cnt_q    <= '0;
      mal_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      opcode_q <= opcode_d;
      len_q    <= len_d;
      ebc_q    <= ebc_d;
      h0_q     <= h0_d;
      h1_q     <= h1_d;
      prop_q   <= prop_d;
      uuid_q   <= uuid_d;
      err0_q   <= err0_d;
      err1_q   <= err1_d;
      cidx_q   <= cidx_d;
      cnt_q    <= cnt_d;
      mal_q    <= mal_d;
    end
  end

endmodule

@@ hdl/arp_queue.sv @@
// ----------------------------------------------------------------------------
// arp_queue: bundle queue between front and back of the ATT response parser
// Small register-based FIFO; pop data comes straight from the head entry.
// ----------------------------------------------------------------------------
module arp_queue import arp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bundle_t    push_data_i,
  input  logic       pop_i,
  output bundle_t    pop_data_o,
  output q_status_t  status_o
);

  bundle_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + QCNT_W'(1)))
    else $error("queue count lost a push");
`endif

endmodule

@@ hdl/arp_back.sv @@
// ----------------------------------------------------------------------------
// arp_back: result emitter of the ATT response parser
// Holds one bundle and hands out its data record, then its end status.
// ----------------------------------------------------------------------------
module arp_back import arp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bundle_t     pop_data_i,
  input  q_status_t   q_status_i,
  output logic        pop_o,
  arp_rec_if.source   rec_o
);

  bundle_t bun_q, bun_d;
  logic    vld_q, vld_d;
  logic    fire;
  logic    load;

  assign fire  = vld_q && rec_o.ready;
  // free to take the next bundle once the current one is fully delivered
  assign load  = !vld_q || (fire && !(bun_q.has_main && bun_q.has_end));
  assign pop_o = load && !q_status_i.empty;

  always_comb begin
    bun_d = bun_q;
    vld_d = vld_q;
    if (fire && bun_q.has_main && bun_q.has_end) begin
      bun_d.has_main = 1'b0;
    end else if (load) begin
      vld_d = !q_status_i.empty;
      bun_d = pop_data_i;
    end
  end

  always_comb begin
    rec_o.valid         = vld_q;
    rec_o.kind          = KIND_END;
    rec_o.record_index  = '0;
    rec_o.first_handle  = '0;
    rec_o.second_handle = '0;
    rec_o.attr_byte     = '0;
    rec_o.err_code      = '0;
    rec_o.uuid_bytes    = '0;
    rec_o.uuid_low      = '0;
    rec_o.uuid_high     = '0;
    rec_o.status        = '0;
    rec_o.entry_count   = '0;
    rec_o.last          = 1'b1;
    if (bun_q.has_main) begin
      rec_o.kind          = bun_q.main.kind;
      rec_o.record_index  = bun_q.main.record_index;
      rec_o.first_handle  = bun_q.main.first_handle;
      rec_o.second_handle = bun_q.main.second_handle;
      rec_o.attr_byte     = bun_q.main.attr_byte;
      rec_o.err_code      = bun_q.main.err_code;
      rec_o.uuid_bytes    = bun_q.main.uuid_bytes;
      rec_o.uuid_low      = bun_q.main.uuid_low;
      rec_o.uuid_high     = bun_q.main.uuid_high;
      rec_o.last          = !bun_q.has_end;
    end else begin
      rec_o.status      = bun_q.end_status;
      rec_o.entry_count = bun_q.end_count;
    end
  end

  always_ff @(posedge clk_i) begin
    bun_q <= bun_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

`ifndef ASSERT_OFF
  a_bundle_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (bun_q.has_main || bun_q.has_end))
    else $error("empty bundle held for output");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !rec_o.ready) |=> (vld_q && $stable(bun_q)))
    else $error("record changed while stalled");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !bun_q.has_main) |-> rec_o.last)
    else $error("end status not marked last");
`endif

endmodule
